>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rtt_pkg.sv
package rtt_pkg;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 14;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;
    localparam int HALF_W   = 16;

    localparam logic [HALF_W-1:0] HALF_TIMEOUT_RESET = 16'd2;

    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED        = 3'd0,
        ST_FULL         = 3'd1,
        ST_ACK_MATCHED  = 3'd2,
        ST_ACK_MISSED   = 3'd3,
        ST_RETRANSMIT   = 3'd4,
        ST_NONE_EXPIRED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic append;
        logic advance;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic pend_vld;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/rtt_req_if.sv
interface rtt_req_if;
    logic                       valid;
    logic                       ready;
    logic [rtt_pkg::KIND_W-1:0] kind;
    logic [rtt_pkg::ID_W-1:0]   msg_id;
    logic [rtt_pkg::TIME_W-1:0] now_time;

    modport source (output valid, output kind, output msg_id, output now_time, input ready);
    modport sink (input valid, input kind, input msg_id, input now_time, output ready);
endinterface

>>> rtl/core/rtt_rsp_if.sv
interface rtt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rtt_pkg::STATUS_W-1:0] status;
    logic [rtt_pkg::ID_W-1:0]     result_id;
    logic [rtt_pkg::OCC_W-1:0]    occupancy;
    logic                         last;

    modport source (output valid, output status, output result_id, output occupancy,
                    output last, input ready);
    modport sink (input valid, input status, input result_id, input occupancy,
                  input last, output ready);
endinterface

>>> rtl/core/rtt_cfg_if.sv
interface rtt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rtt_pkg::HALF_W-1:0] half_timeout;

    modport source (output valid, output half_timeout, input ready);
    modport sink (input valid, input half_timeout, output ready);
endinterface

>>> rtl/core/rtt_datapath.sv
module rtt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rtt_pkg::t_dp_cmd             i_cmd,
    output rtt_pkg::t_dp_sts             o_sts,
    input  logic [rtt_pkg::KIND_W-1:0]   i_kind,
    input  logic [rtt_pkg::ID_W-1:0]     i_msg_id,
    input  logic [rtt_pkg::TIME_W-1:0]   i_now_time,
    input  logic                         i_cfg_wr,
    input  logic [rtt_pkg::HALF_W-1:0]   i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [rtt_pkg::STATUS_W-1:0] o_status,
    output logic [rtt_pkg::ID_W-1:0]     o_result_id,
    output logic [rtt_pkg::OCC_W-1:0]    o_occupancy,
    output logic                         o_last
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W   = rtt_pkg::ID_W;
    localparam int TIME_W = rtt_pkg::TIME_W;
    localparam int HALF_W = rtt_pkg::HALF_W;
    localparam int OCC_W  = rtt_pkg::OCC_W;

    logic [ID_W-1:0]   m_id   [TABLE_DEPTH];
    logic [TIME_W-1:0] m_time [TABLE_DEPTH];

    logic [rtt_pkg::KIND_W-1:0] r_kind;
    logic [ID_W-1:0]            r_id;
    logic [TIME_W-1:0]          r_now;
    logic                       r_full;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_ptr;
    logic                       r_rd_vld;
    logic [ADDR_W-1:0]          r_rd_addr;
    logic [ID_W-1:0]            r_rd_id;
    logic [TIME_W-1:0]          r_rd_time;
    logic                       r_found;
    logic                       r_pend_vld;
    logic [ID_W-1:0]            r_pend_id;
    logic [HALF_W-1:0]          r_half;
    logic                       r_out_vld;
    rtt_pkg::t_status           r_out_status;
    logic [ID_W-1:0]            r_out_id;
    logic [OCC_W-1:0]           r_out_occ;
    logic                       r_out_last;

    logic              w_scan_tick;
    logic              w_scan_ack;
    logic [TIME_W-1:0] w_age;
    logic [TIME_W-1:0] w_timeout;
    logic              w_expired;
    logic              w_match;
    logic              w_do_append;
    logic              w_issue;
    logic              w_step;
    logic              w_shift;
    logic              w_found_now;
    logic              w_tick_hit;
    logic              w_push;
    logic              w_out_free;
    logic [CNT_W-1:0]  w_final_count;
    logic [ADDR_W-1:0] w_shift_addr;
    logic              w_id_we;
    logic [ADDR_W-1:0] w_id_waddr;
    logic [ID_W-1:0]   w_id_wdata;
    logic              w_time_we;
    logic [ADDR_W-1:0] w_time_waddr;
    logic [TIME_W-1:0] w_time_wdata;

    assign w_scan_tick   = (r_kind == rtt_pkg::KIND_TICK);
    assign w_scan_ack    = (r_kind == rtt_pkg::KIND_ACK);
    assign w_age         = r_now - r_rd_time;
    assign w_timeout     = {{(TIME_W - HALF_W - 1){1'b0}}, r_half, 1'b0};
    assign w_expired     = (w_age > w_timeout);
    assign w_match       = (r_rd_id == r_id);
    assign w_do_append   = i_cmd.append && !r_full;
    assign w_issue       = i_cmd.advance && (r_ptr < r_count);
    assign w_step        = i_cmd.advance && r_rd_vld;
    assign w_shift       = w_step && w_scan_ack && r_found;
    assign w_found_now   = w_step && w_scan_ack && !r_found && w_match;
    assign w_tick_hit    = w_step && w_scan_tick && w_expired;
    assign w_push        = w_tick_hit && r_pend_vld;
    assign w_out_free    = !r_out_vld || i_out_ready;
    assign w_final_count = r_count - CNT_W'(r_found);
    assign w_shift_addr  = r_rd_addr - ADDR_W'(1);

    assign o_sts.scan_done = !r_rd_vld && (r_ptr == r_count);
    assign o_sts.hit       = r_rd_vld && w_scan_tick && w_expired;
    assign o_sts.pend_vld  = r_pend_vld;
    assign o_sts.out_free  = w_out_free;

    // Write port select: append at the tail, shift down on ack, restamp on tick.
    always_comb begin
        w_id_we      = w_do_append || w_shift;
        w_id_waddr   = w_do_append ? r_count[ADDR_W-1:0] : w_shift_addr;
        w_id_wdata   = w_do_append ? r_id : r_rd_id;
        w_time_we    = w_do_append || w_shift || w_tick_hit;
        w_time_waddr = r_rd_addr;
        w_time_wdata = r_now;
        if (w_do_append) begin
            w_time_waddr = r_count[ADDR_W-1:0];
        end else if (w_shift) begin
            w_time_waddr = w_shift_addr;
            w_time_wdata = r_rd_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_id_we) begin
            m_id[w_id_waddr] <= w_id_wdata;
        end
        if (w_issue) begin
            r_rd_id <= m_id[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_time_we) begin
            m_time[w_time_waddr] <= w_time_wdata;
        end
        if (w_issue) begin
            r_rd_time <= m_time[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= rtt_pkg::KIND_SEND;
            r_count    <= '0;
            r_ptr      <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_half     <= rtt_pkg::HALF_TIMEOUT_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_half <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_kind     <= i_kind;
                r_ptr      <= '0;
                r_rd_vld   <= 1'b0;
                r_found    <= 1'b0;
                r_pend_vld <= 1'b0;
            end
            if (w_do_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.advance) begin
                r_rd_vld <= w_issue;
            end
            if (w_issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (w_found_now) begin
                r_found <= 1'b1;
            end
            if (w_tick_hit) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count <= w_final_count;
            end
            if (w_push || i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id   <= i_msg_id;
            r_now  <= i_now_time;
            r_full <= (r_count >= CNT_W'(TABLE_DEPTH));
        end
        if (w_issue) begin
            r_rd_addr <= r_ptr[ADDR_W-1:0];
        end
        // Hold back each expired entry until the next one shows whether it is the final one.
        if (w_tick_hit) begin
            r_pend_id <= r_rd_id;
        end
        if (w_push) begin
            r_out_status <= rtt_pkg::ST_RETRANSMIT;
            r_out_id     <= r_pend_id;
            r_out_occ    <= OCC_W'(r_count);
            r_out_last   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_last <= 1'b1;
            case (r_kind)
                rtt_pkg::KIND_SEND: begin
                    r_out_status <= r_full ? rtt_pkg::ST_FULL : rtt_pkg::ST_ADDED;
                    r_out_id     <= r_id;
                    r_out_occ    <= OCC_W'(r_count);
                end
                rtt_pkg::KIND_ACK: begin
                    r_out_status <= r_found ? rtt_pkg::ST_ACK_MATCHED : rtt_pkg::ST_ACK_MISSED;
                    r_out_id     <= r_id;
                    r_out_occ    <= OCC_W'(w_final_count);
                end
                default: begin
                    r_out_status <= r_pend_vld ? rtt_pkg::ST_RETRANSMIT
                                               : rtt_pkg::ST_NONE_EXPIRED;
                    r_out_id     <= r_pend_vld ? r_pend_id : '0;
                    r_out_occ    <= OCC_W'(r_count);
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_result_id = r_out_id;
    assign o_occupancy = r_out_occ;
    assign o_last      = r_out_last;

endmodule

>>> rtl/core/rtt_ctrl.sv
module rtt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic [rtt_pkg::KIND_W-1:0] i_kind,
    input  rtt_pkg::t_dp_sts           i_sts,
    output logic                       o_req_ready,
    output rtt_pkg::t_dp_cmd           o_cmd
);

    rtt_pkg::t_state r_state;
    rtt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            rtt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        rtt_pkg::KIND_SEND: n_state = rtt_pkg::S_APPEND;
                        rtt_pkg::KIND_ACK,
                        rtt_pkg::KIND_TICK: n_state = rtt_pkg::S_SCAN;
                        default:            n_state = rtt_pkg::S_IDLE;
                    endcase
                end
            end
            rtt_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = rtt_pkg::S_FINISH;
            end
            rtt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = rtt_pkg::S_FINISH;
                end else begin
                    // Hold the walk while a held retransmit cannot move to the output.
                    o_cmd.advance = !(i_sts.hit && i_sts.pend_vld && !i_sts.out_free);
                end
            end
            rtt_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = rtt_pkg::S_IDLE;
                end
            end
            default: n_state = rtt_pkg::S_IDLE;
        endcase
    end

endmodule

>>> rtl/core/retransmit_tracking_table_core.sv
// Send: after acceptance S_APPEND appends, then S_FINISH registers the result once the
// output register is free and returns to S_IDLE. Ack and tick: the single read port
// walks the id and send-time memories of N entries (N up to TABLE_DEPTH) one entry a
// cycle, but tick results may stall it while the output register is held by the sink.
// Synchronous active-low reset empties the table and sets half_timeout to 2; the
// memories themselves are not cleared and need no clearing pass.
`include "assert_macros.svh"

module retransmit_tracking_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtt_req_if.sink   i_req,
    rtt_rsp_if.source o_rsp,
    rtt_cfg_if.sink   i_cfg
);

    rtt_pkg::t_dp_cmd w_cmd;
    rtt_pkg::t_dp_sts w_sts;
    logic             w_req_ready;

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = 1'b1;

    rtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_kind      (i_req.kind),
        .i_sts       (w_sts),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    rtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (i_req.kind),
        .i_msg_id    (i_req.msg_id),
        .i_now_time  (i_req.now_time),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_data  (i_cfg.half_timeout),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_result_id (o_rsp.result_id),
        .o_occupancy (o_rsp.occupancy),
        .o_last      (o_rsp.last)
    );

    `ASSERT_IMPLIES(a_finish_needs_slot, i_clk, i_rst_n, w_cmd.finish, w_sts.out_free, "final result loaded over a pending one")
    `ASSERT_IMPLIES(a_push_needs_slot, i_clk, i_rst_n, w_cmd.advance && w_sts.hit && w_sts.pend_vld, w_sts.out_free, "retransmit pushed over a pending result")
    `ASSERT_NEXT(a_send_busy, i_clk, i_rst_n, i_req.valid && w_req_ready && (i_req.kind == rtt_pkg::KIND_SEND), !w_req_ready, "send transaction did not occupy the block")

endmodule
